/* src/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the sequencer checkers.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, off while reset is asserted.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, off while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

// Next-cycle implication that also holds through reset.
`define ASSERT_NEXT_ALWAYS(label, clk, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

/* src/snor_seq_pkg.sv */
// ----------------------------------------------------------------------------
// SPI NOR sequencer package
// Types, command and result codes, flash opcodes and sequencer phases.
// ----------------------------------------------------------------------------
package snor_seq_pkg;

  localparam int ADDR_W = 24;
  localparam int LEN_W  = 17;
  localparam int QUEUE_DEPTH = 4;

  localparam logic [LEN_W-1:0] MAX_LENGTH_RESET = 17'd4096;

  // host commands
  localparam logic [2:0] CMD_READ   = 3'd0;
  localparam logic [2:0] CMD_WRITE  = 3'd1;
  localparam logic [2:0] CMD_ERASE  = 3'd2;
  localparam logic [2:0] CMD_WREN   = 3'd3;
  localparam logic [2:0] CMD_STATUS = 3'd4;
  localparam logic [2:0] CMD_WDATA  = 3'd5;
  localparam logic [2:0] CMD_MISO   = 3'd6;

  // result kinds
  localparam logic [2:0] KIND_EXCH    = 3'd0;
  localparam logic [2:0] KIND_RDATA   = 3'd1;
  localparam logic [2:0] KIND_STATUS  = 3'd2;
  localparam logic [2:0] KIND_NEED    = 3'd3;
  localparam logic [2:0] KIND_DONE    = 3'd4;
  localparam logic [2:0] KIND_LEN_ERR = 3'd5;

  // flash opcodes
  localparam logic [7:0] OP_READ      = 8'h03;
  localparam logic [7:0] OP_FAST_READ = 8'h0B;
  localparam logic [7:0] OP_PROGRAM   = 8'h02;
  localparam logic [7:0] OP_ERASE     = 8'h20;
  localparam logic [7:0] OP_WREN      = 8'h06;
  localparam logic [7:0] OP_RDSR      = 8'h05;

  localparam logic [1:0] POLL_BUSY = 2'd1;
  localparam logic [1:0] POLL_WEL  = 2'd2;

  typedef enum logic [3:0] {
    PH_IDLE,
    PH_RD_HDR,
    PH_RD_DATA,
    PH_ST_OP,
    PH_ST_VAL,
    PH_POLL_OP,
    PH_POLL_VAL,
    PH_WREN_SENT,
    PH_ER_HDR,
    PH_PP_HDR,
    PH_WAIT_BYTE,
    PH_PP_DATA
  } phase_t;

  typedef struct packed {
    logic [2:0]        cmd;
    logic [ADDR_W-1:0] addr;
    logic [LEN_W-1:0]  len;
    logic [7:0]        data;
  } item_t;

  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] value;
    logic       end_frame;
    logic       last;
  } res_t;

  typedef struct packed {
    logic [1:0]      cnt;
    res_t [1:0]      res;
  } push_t;

endpackage

/* src/snor_seq_step.sv */
// ----------------------------------------------------------------------------
// SPI NOR sequencer step
// Sequencer state and the single-pass decision for one registered item.
// ----------------------------------------------------------------------------
module snor_seq_step
  import snor_seq_pkg::*;
#(
  parameter int PAGE_BYTES = 256
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             fire,
  input  item_t            item,
  input  logic [LEN_W-1:0] max_length,
  output push_t            push
);

  localparam int PAGE_W = $clog2(PAGE_BYTES);
  localparam int PBL_W  = PAGE_W + 1;

  phase_t              phase_r, phase_nxt;
  logic [2:0]          op_r, op_nxt;
  logic [ADDR_W-1:0]   addr_r, addr_nxt;
  logic [LEN_W-1:0]    rem_r, rem_nxt;
  logic [PBL_W-1:0]    pbl_r, pbl_nxt;
  logic [2:0]          fbi_r, fbi_nxt;
  logic [1:0]          mask_r, mask_nxt;

  logic [2:0]          fbi_inc;
  logic [7:0]          hdr;
  logic [PBL_W-1:0]    room;
  logic [PBL_W-1:0]    batch;
  logic [LEN_W-1:0]    rem_dec;
  logic [PBL_W-1:0]    pbl_dec;
  logic                rem_one;
  res_t                r0, r1;
  logic [1:0]          cnt;

  function automatic res_t mk(input logic [2:0] kind, input logic [7:0] value,
                              input logic end_frame);
    res_t r;
    r.kind      = kind;
    r.value     = value;
    r.end_frame = end_frame;
    r.last      = 1'b0;
    return r;
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      op_r    <= '0;
      addr_r  <= '0;
      rem_r   <= '0;
      pbl_r   <= '0;
      fbi_r   <= '0;
      mask_r  <= '0;
    end else if (fire) begin
      phase_r <= phase_nxt;
      op_r    <= op_nxt;
      addr_r  <= addr_nxt;
      rem_r   <= rem_nxt;
      pbl_r   <= pbl_nxt;
      fbi_r   <= fbi_nxt;
      mask_r  <= mask_nxt;
    end
  end

  assign rem_one = (rem_r == LEN_W'(1));
  assign fbi_inc = fbi_r + 3'd1;
  assign rem_dec = (rem_r != '0) ? rem_r - LEN_W'(1) : rem_r;
  assign pbl_dec = (pbl_r != '0) ? pbl_r - PBL_W'(1) : pbl_r;

  // room left in the current page, then the size of the next program batch
  assign room  = PBL_W'(PAGE_BYTES) - {1'b0, addr_r[PAGE_W-1:0]};
  assign batch = (rem_r < LEN_W'(room)) ? PBL_W'(rem_r) : room;

  // header byte for the advanced frame index
  always_comb begin
    case (fbi_inc)
      3'd1:    hdr = addr_r[23:16];
      3'd2:    hdr = addr_r[15:8];
      3'd3:    hdr = addr_r[7:0];
      default: hdr = 8'h00;
    endcase
  end

  always_comb begin
    phase_nxt = phase_r;
    op_nxt    = op_r;
    addr_nxt  = addr_r;
    rem_nxt   = rem_r;
    pbl_nxt   = pbl_r;
    fbi_nxt   = fbi_r;
    mask_nxt  = mask_r;
    r0        = '0;
    r1        = '0;
    cnt       = 2'd0;

    unique case (phase_r)
      PH_IDLE: begin
        unique case (item.cmd)
          CMD_READ: begin
            if (item.len == '0 || item.len > max_length) begin
              r0  = mk(KIND_LEN_ERR, 8'h00, 1'b0);
              cnt = 2'd1;
            end else begin
              op_nxt    = CMD_READ;
              addr_nxt  = item.addr;
              rem_nxt   = item.len;
              fbi_nxt   = '0;
              phase_nxt = PH_RD_HDR;
              r0  = mk(KIND_EXCH, (item.len == LEN_W'(1)) ? OP_READ : OP_FAST_READ, 1'b0);
              cnt = 2'd1;
            end
          end
          CMD_WRITE: begin
            op_nxt    = CMD_WRITE;
            addr_nxt  = item.addr;
            rem_nxt   = item.len;
            pbl_nxt   = '0;
            mask_nxt  = POLL_BUSY;
            phase_nxt = PH_POLL_OP;
            r0  = mk(KIND_EXCH, OP_RDSR, 1'b0);
            cnt = 2'd1;
          end
          CMD_ERASE: begin
            op_nxt    = CMD_ERASE;
            addr_nxt  = item.addr;
            fbi_nxt   = '0;
            phase_nxt = PH_ER_HDR;
            r0  = mk(KIND_EXCH, OP_ERASE, 1'b0);
            cnt = 2'd1;
          end
          CMD_WREN: begin
            op_nxt    = CMD_WREN;
            phase_nxt = PH_WREN_SENT;
            r0  = mk(KIND_EXCH, OP_WREN, 1'b1);
            cnt = 2'd1;
          end
          CMD_STATUS: begin
            op_nxt    = CMD_STATUS;
            phase_nxt = PH_ST_OP;
            r0  = mk(KIND_EXCH, OP_RDSR, 1'b0);
            cnt = 2'd1;
          end
          default: ;
        endcase
      end

      PH_WAIT_BYTE: begin
        if (item.cmd == CMD_WDATA) begin
          phase_nxt = PH_PP_DATA;
          r0  = mk(KIND_EXCH, item.data, pbl_r == PBL_W'(1));
          cnt = 2'd1;
        end
      end

      default: begin
        if (item.cmd == CMD_MISO) begin
          unique case (phase_r)
            PH_RD_HDR: begin
              fbi_nxt = fbi_inc;
              // opcode, three address bytes, then a dummy byte for fast read
              if (fbi_inc < (rem_one ? 3'd4 : 3'd5)) begin
                r0 = mk(KIND_EXCH, hdr, 1'b0);
              end else begin
                phase_nxt = PH_RD_DATA;
                r0 = mk(KIND_EXCH, 8'h00, rem_one);
              end
              cnt = 2'd1;
            end
            PH_RD_DATA: begin
              rem_nxt = rem_dec;
              r0 = mk(KIND_RDATA, item.data, 1'b0);
              if (rem_dec == '0) begin
                phase_nxt = PH_IDLE;
                r1 = mk(KIND_DONE, 8'h00, 1'b0);
              end else begin
                r1 = mk(KIND_EXCH, 8'h00, rem_dec == LEN_W'(1));
              end
              cnt = 2'd2;
            end
            PH_ST_OP: begin
              phase_nxt = PH_ST_VAL;
              r0  = mk(KIND_EXCH, 8'h00, 1'b1);
              cnt = 2'd1;
            end
            PH_ST_VAL: begin
              phase_nxt = PH_IDLE;
              r0  = mk(KIND_STATUS, item.data, 1'b0);
              r1  = mk(KIND_DONE, 8'h00, 1'b0);
              cnt = 2'd2;
            end
            PH_POLL_OP: begin
              phase_nxt = PH_POLL_VAL;
              r0  = mk(KIND_EXCH, 8'h00, 1'b1);
              cnt = 2'd1;
            end
            PH_POLL_VAL: begin
              cnt = 2'd1;
              if ((item.data[1:0] & mask_r) != 2'b00) begin
                // still busy: poll again
                phase_nxt = PH_POLL_OP;
                r0 = mk(KIND_EXCH, OP_RDSR, 1'b0);
              end else if (op_r != CMD_WRITE) begin
                phase_nxt = PH_IDLE;
                r0 = mk(KIND_DONE, 8'h00, 1'b0);
              end else if (mask_r == POLL_WEL || pbl_r == '0) begin
                if (rem_r == '0) begin
                  phase_nxt = PH_IDLE;
                  r0 = mk(KIND_DONE, 8'h00, 1'b0);
                end else begin
                  pbl_nxt   = batch;
                  phase_nxt = PH_WREN_SENT;
                  r0 = mk(KIND_EXCH, OP_WREN, 1'b1);
                end
              end else begin
                phase_nxt = PH_PP_HDR;
                fbi_nxt   = '0;
                r0 = mk(KIND_EXCH, OP_PROGRAM, 1'b0);
              end
            end
            PH_WREN_SENT: begin
              mask_nxt  = POLL_BUSY;
              phase_nxt = PH_POLL_OP;
              r0  = mk(KIND_EXCH, OP_RDSR, 1'b0);
              cnt = 2'd1;
            end
            PH_ER_HDR: begin
              fbi_nxt = fbi_inc;
              if (fbi_inc < 3'd4) begin
                r0 = mk(KIND_EXCH, hdr, fbi_inc == 3'd3);
              end else begin
                mask_nxt  = POLL_BUSY;
                phase_nxt = PH_POLL_OP;
                r0 = mk(KIND_EXCH, OP_RDSR, 1'b0);
              end
              cnt = 2'd1;
            end
            PH_PP_HDR: begin
              fbi_nxt = fbi_inc;
              if (fbi_inc < 3'd4) begin
                r0 = mk(KIND_EXCH, hdr, 1'b0);
              end else begin
                phase_nxt = PH_WAIT_BYTE;
                r0 = mk(KIND_NEED, 8'h00, 1'b0);
              end
              cnt = 2'd1;
            end
            PH_PP_DATA: begin
              pbl_nxt  = pbl_dec;
              rem_nxt  = rem_dec;
              addr_nxt = addr_r + ADDR_W'(1);
              if (pbl_dec != '0) begin
                phase_nxt = PH_WAIT_BYTE;
                r0 = mk(KIND_NEED, 8'h00, 1'b0);
              end else begin
                mask_nxt  = POLL_WEL;
                phase_nxt = PH_POLL_OP;
                r0 = mk(KIND_EXCH, OP_RDSR, 1'b0);
              end
              cnt = 2'd1;
            end
            default: ;
          endcase
        end
      end
    endcase

    // mark the final result of this transfer
    if (cnt == 2'd1) r0.last = 1'b1;
    if (cnt == 2'd2) r1.last = 1'b1;

    push.cnt    = fire ? cnt : 2'd0;
    push.res[0] = r0;
    push.res[1] = r1;
  end

endmodule

/* src/snor_seq_outq.sv */
// ----------------------------------------------------------------------------
// SPI NOR sequencer result queue
// Shift queue taking up to two results a cycle and presenting one at the head.
// ----------------------------------------------------------------------------
module snor_seq_outq
  import snor_seq_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  push_t push,
  output logic  room,
  output logic  out_valid,
  input  logic  out_ready,
  output res_t  head
);

  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  res_t          slot_r   [QUEUE_DEPTH];
  res_t          slot_nxt [QUEUE_DEPTH];
  logic [CW-1:0] count_r, count_nxt;
  logic [CW-1:0] base;
  logic          pop;

  assign out_valid = (count_r != '0);
  assign head      = slot_r[0];
  assign pop       = out_valid && out_ready;
  assign base      = count_r - CW'(pop);
  assign count_nxt = base + CW'(push.cnt);
  // two free slots guarantee space for any transfer
  assign room      = (count_r <= CW'(QUEUE_DEPTH - 2));

  always_comb begin
    for (int i = 0; i < QUEUE_DEPTH; i++) slot_nxt[i] = slot_r[i];
    if (pop) begin
      for (int i = 0; i < QUEUE_DEPTH - 1; i++) slot_nxt[i] = slot_r[i + 1];
    end
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      if (push.cnt != 2'd0 && CW'(i) == base) slot_nxt[i] = push.res[0];
      if (push.cnt == 2'd2 && CW'(i) == base + CW'(1)) slot_nxt[i] = push.res[1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    slot_r <= slot_nxt;
  end

endmodule

/* src/spi_nor_flash_command_sequencer_core.sv */
// ----------------------------------------------------------------------------
// SPI NOR flash command sequencer core
// Turns host read, page write, sector erase, write enable and status commands
// into SPI byte exchanges, one decision per received MISO byte or host byte.
// Each accepted transfer is registered, decided in a single pass and yields zero
// to two results into a four-entry result queue; a new transfer is taken every
// cycle while the queue holds two or fewer results, so the sustained rate is
// one item per clock whenever the result side keeps up. A transfer is held
// in the input register, then its results in the queue. Writes are split at
// PAGE_BYTES boundaries, which must be a power of two.
// ----------------------------------------------------------------------------
module spi_nor_flash_command_sequencer_core
  import snor_seq_pkg::*;
#(
  parameter int PAGE_BYTES = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [55:0] in_tdata,   // address[23:0], length[40:24], data_byte[48:41]
  input  logic [2:0]  in_tuser,   // command[2:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // value[7:0], end_frame[8]
  output logic [2:0]  out_tuser,  // kind[2:0]
  output logic        out_tlast,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [16:0] cfg_data    // max_length[16:0]
);

  logic             in_valid_r;
  item_t            in_item_r;
  logic [LEN_W-1:0] max_length_r;
  logic             fire;
  logic             room;
  push_t            push;
  res_t             head;

  assign fire      = in_valid_r && room;
  assign in_tready = !in_valid_r || fire;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_item_r.cmd  <= in_tuser;
      in_item_r.addr <= in_tdata[23:0];
      in_item_r.len  <= in_tdata[40:24];
      in_item_r.data <= in_tdata[48:41];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_length_r <= MAX_LENGTH_RESET;
    end else if (cfg_valid && cfg_ready) begin
      max_length_r <= cfg_data;
    end
  end

  snor_seq_step #(
    .PAGE_BYTES(PAGE_BYTES)
  ) u_step (
    .clk       (clk),
    .rst_n     (rst_n),
    .fire      (fire),
    .item      (in_item_r),
    .max_length(max_length_r),
    .push      (push)
  );

  snor_seq_outq u_outq (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .room     (room),
    .out_valid(out_tvalid),
    .out_ready(out_tready),
    .head     (head)
  );

  assign out_tdata = {7'b0, head.end_frame, head.value};
  assign out_tuser = head.kind;
  assign out_tlast = head.last;

endmodule

/* src/snor_seq_checker.sv */
// ----------------------------------------------------------------------------
// SPI NOR sequencer checker
// Port-level checks on the result stream, bound to the core.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module snor_seq_checker
  import snor_seq_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [15:0] out_tdata,
  input logic [2:0]  out_tuser,
  input logic        out_tlast
);

  // hold a stalled result
  `ASSERT_NEXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tuser) && $stable(out_tlast))

  // reset drains the result queue
  `ASSERT_NEXT_ALWAYS(a_reset_empty, clk, !rst_n, !out_tvalid)

  `ASSERT_IMPLIES(a_kind_legal, clk, rst_n, out_tvalid, out_tuser == KIND_EXCH || out_tuser == KIND_RDATA || out_tuser == KIND_STATUS || out_tuser == KIND_NEED || out_tuser == KIND_DONE || out_tuser == KIND_LEN_ERR)

  // chip select release only rides on an exchange
  `ASSERT_IMPLIES(a_frame_exch, clk, rst_n, out_tvalid && out_tuser != KIND_EXCH, out_tdata[8] == 1'b0)

  `ASSERT_IMPLIES(a_event_zero, clk, rst_n, out_tvalid && (out_tuser == KIND_NEED || out_tuser == KIND_DONE || out_tuser == KIND_LEN_ERR), out_tdata[7:0] == 8'h00)

endmodule

bind spi_nor_flash_command_sequencer_core snor_seq_checker u_snor_seq_checker (.*);
